// ===== src/tlsch_pkg.sv =====
// Package for the TLS ClientHello parser: phase codes, result kinds, status codes.
// No dependencies.
package tlsch_pkg;

    localparam int RANDOM_LEN_DEF = 32;

    localparam logic [7:0] REC_HANDSHAKE   = 8'd22;
    localparam logic [7:0] HS_CLIENT_HELLO = 8'd1;

    localparam logic [15:0] EXT_SNI    = 16'd0;
    localparam logic [15:0] EXT_STATUS = 16'd5;
    localparam logic [15:0] EXT_GROUPS = 16'd10;
    localparam logic [15:0] EXT_PTFMT  = 16'd11;
    localparam logic [15:0] EXT_SIGALG = 16'd13;
    localparam logic [15:0] EXT_ALPN   = 16'd16;

    typedef enum logic [4:0] {
        PH_REC, PH_HS, PH_RAND, PH_SIDLEN, PH_SID, PH_CSLEN, PH_CS, PH_CMLEN, PH_CM,
        PH_EXTLEN, PH_EXTHDR, PH_SKIP, PH_SNI_LL, PH_SNI_EH, PH_SNI_NAME, PH_L16_LEN,
        PH_L16_BODY, PH_PF_LEN, PH_PF_BODY, PH_ALPN_LL, PH_ALPN_PLEN, PH_ALPN_NAME
    } phase_t;

    localparam logic [3:0] K_NONE   = 4'd0;
    localparam logic [3:0] K_RECVER = 4'd1;
    localparam logic [3:0] K_HSVER  = 4'd2;
    localparam logic [3:0] K_RANDOM = 4'd3;
    localparam logic [3:0] K_SESS   = 4'd4;
    localparam logic [3:0] K_CIPHER = 4'd5;
    localparam logic [3:0] K_COMPR  = 4'd6;
    localparam logic [3:0] K_SNI    = 4'd7;
    localparam logic [3:0] K_ALPN   = 4'd8;
    localparam logic [3:0] K_SIGALG = 4'd9;
    localparam logic [3:0] K_GROUP  = 4'd10;
    localparam logic [3:0] K_PTFMT  = 4'd11;
    localparam logic [3:0] K_OCSP   = 4'd12;
    localparam logic [3:0] K_OTHER  = 4'd13;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BADLEN  = 2'd1;
    localparam logic [1:0] ST_BADTYPE = 2'd2;
    localparam logic [1:0] ST_EXTLEN  = 2'd3;

    localparam int RES_W = 4 + 16 + 16 + 16 + 1 + 2;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] value;
        logic [15:0] aux;
        logic [15:0] position;
        logic        done_res;
        logic [1:0]  status;
    } result_t;

endpackage

// ===== src/tls_client_hello_parser_core.sv =====
// TLS ClientHello parser.
// Usage:
//   s_ channel carries one record byte per beat (s_data_byte, s_last_byte).
//   m_ channel carries tagged results: kind, value, aux, position, done_res, status.
//   A beat produces zero or one result; the final byte always produces one with
//   done_res set and the record status, after which the parser is ready for a
//   new record.
//   Each result enters the output queue in the cycle after its input beat.
//   Throughput: one byte per cycle while the output queue is not full.
//   The two-entry queue decouples the sides; s_ready drops only when it is full
//   because m_ready is held low.
//   Reset (aresetn low, synchronous) clears the parser and empties the queue.
// Depends on tlsch_pkg, tlsch_front, tlsch_fifo.
module tls_client_hello_parser_core #(
    parameter int RANDOM_LEN = tlsch_pkg::RANDOM_LEN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_kind,
    output logic [15:0] m_value,
    output logic [15:0] m_aux,
    output logic [15:0] m_position,
    output logic        m_done_res,
    output logic [1:0]  m_status
);

    logic               step, have, full;
    tlsch_pkg::result_t res, q;

    assign s_ready = !full;
    assign step    = s_valid && s_ready;

    tlsch_front #(.RANDOM_LEN(RANDOM_LEN)) u_front (
        .aclk(aclk), .aresetn(aresetn), .step(step),
        .data_byte(s_data_byte), .last_byte(s_last_byte),
        .res_have(have), .res(res)
    );

    tlsch_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn), .wr_en(step && have), .wr_data(res),
        .full(full), .rd_valid(m_valid), .rd_en(m_valid && m_ready), .rd_data(q)
    );

    assign m_kind     = q.kind;
    assign m_value    = q.value;
    assign m_aux      = q.aux;
    assign m_position = q.position;
    assign m_done_res = q.done_res;
    assign m_status   = q.status;

    ap_last: assert property (@(posedge aclk) disable iff (!aresetn)
        step && s_last_byte |=> m_valid) else $error("final result missing");
    ap_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_done_res |-> m_status == tlsch_pkg::ST_OK)
        else $error("status on non-final result");
    ap_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_kind <= tlsch_pkg::K_OTHER) else $error("bad kind");

endmodule

// ===== src/tlsch_front.sv =====
// Front end: byte-walking parser state machine; produces one result per emitting beat.
// Depends on tlsch_pkg.
module tlsch_front #(
    parameter int RANDOM_LEN = tlsch_pkg::RANDOM_LEN_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    output logic                 res_have,
    output tlsch_pkg::result_t   res
);

    tlsch_pkg::phase_t phase_reg, phase_next;
    logic [15:0] fc_reg, fc_next;
    logic [15:0] extrem_reg, extrem_next;
    logic [15:0] inner_reg, inner_next;
    logic [15:0] entry_reg, entry_next;
    logic [15:0] asm_reg, asm_next;
    logic [15:0] etype_reg, etype_next;
    logic [15:0] enum_reg, enum_next;
    logic [7:0]  ekind_reg, ekind_next;
    logic [1:0]  err_reg, err_next;
    logic        half_reg, half_next;
    logic [15:0] pos_reg, pos_next;

    logic        have;
    logic [3:0]  o_kind;
    logic [15:0] o_val, o_aux, o_pos;
    logic [15:0] rest, len16, word;
    logic [1:0]  stat;

    always_comb begin
        phase_next  = phase_reg;
        fc_next     = fc_reg;
        extrem_next = extrem_reg;
        inner_next  = inner_reg;
        entry_next  = entry_reg;
        asm_next    = asm_reg;
        etype_next  = etype_reg;
        enum_next   = enum_reg;
        ekind_next  = ekind_reg;
        err_next    = err_reg;
        half_next   = half_reg;
        pos_next    = pos_reg;
        have   = 1'b0;
        o_kind = tlsch_pkg::K_NONE;
        o_val  = '0;
        o_aux  = '0;
        o_pos  = '0;
        rest   = inner_reg;
        word   = asm_reg | {8'd0, data_byte};
        len16  = word;
        if (err_reg == tlsch_pkg::ST_OK) begin
            if (phase_reg >= tlsch_pkg::PH_EXTHDR && extrem_reg != 16'd0)
                extrem_next = extrem_reg - 16'd1;
            if (phase_reg == tlsch_pkg::PH_SNI_EH && fc_reg == 16'd0 && inner_reg < 16'd3) begin
                err_next = tlsch_pkg::ST_EXTLEN;
            end else begin
                if (phase_reg > tlsch_pkg::PH_EXTHDR && inner_reg != 16'd0)
                    inner_next = inner_reg - 16'd1;
                rest = (phase_reg > tlsch_pkg::PH_EXTHDR && inner_reg != 16'd0) ?
                       inner_reg - 16'd1 : inner_reg;
                fc_next = fc_reg + 16'd1;
                case (phase_reg)
                    tlsch_pkg::PH_REC: begin
                        if (fc_reg == 16'd0) ekind_next = data_byte;
                        else if (fc_reg == 16'd1) asm_next = {data_byte, 8'd0};
                        else if (fc_reg == 16'd2) begin
                            asm_next = word;
                            if (ekind_reg == tlsch_pkg::REC_HANDSHAKE) begin
                                have = 1'b1; o_kind = tlsch_pkg::K_RECVER; o_val = word;
                            end
                        end else if (fc_reg >= 16'd4) begin
                            if (ekind_reg != tlsch_pkg::REC_HANDSHAKE)
                                err_next = tlsch_pkg::ST_BADTYPE;
                            else begin
                                phase_next = tlsch_pkg::PH_HS; fc_next = '0; half_next = 1'b0;
                            end
                        end
                    end
                    tlsch_pkg::PH_HS: begin
                        if (fc_reg == 16'd0) ekind_next = data_byte;
                        else if (fc_reg == 16'd4) asm_next = {data_byte, 8'd0};
                        else if (fc_reg >= 16'd5) begin
                            if (ekind_reg != tlsch_pkg::HS_CLIENT_HELLO)
                                err_next = tlsch_pkg::ST_BADTYPE;
                            else begin
                                have = 1'b1; o_kind = tlsch_pkg::K_HSVER; o_val = word;
                                pos_next = '0;
                                phase_next = tlsch_pkg::PH_RAND; fc_next = '0; half_next = 1'b0;
                            end
                        end
                    end
                    tlsch_pkg::PH_RAND: begin
                        have = 1'b1; o_kind = tlsch_pkg::K_RANDOM;
                        o_val = {8'd0, data_byte}; o_pos = pos_reg;
                        pos_next = pos_reg + 16'd1;
                        if (pos_reg + 16'd1 >= 16'(RANDOM_LEN)) begin
                            phase_next = tlsch_pkg::PH_SIDLEN; fc_next = '0; half_next = 1'b0;
                        end
                    end
                    tlsch_pkg::PH_SIDLEN: begin
                        entry_next = {8'd0, data_byte}; pos_next = '0;
                        phase_next = (data_byte != 8'd0) ? tlsch_pkg::PH_SID
                                                         : tlsch_pkg::PH_CSLEN;
                        fc_next = '0; half_next = 1'b0;
                    end
                    tlsch_pkg::PH_SID, tlsch_pkg::PH_CM, tlsch_pkg::PH_PF_BODY,
                    tlsch_pkg::PH_SNI_NAME, tlsch_pkg::PH_ALPN_NAME: begin
                        o_val = {8'd0, data_byte}; o_pos = pos_reg;
                        have = 1'b1;
                        case (phase_reg)
                            tlsch_pkg::PH_SID:      o_kind = tlsch_pkg::K_SESS;
                            tlsch_pkg::PH_CM:       o_kind = tlsch_pkg::K_COMPR;
                            tlsch_pkg::PH_PF_BODY:  o_kind = tlsch_pkg::K_PTFMT;
                            tlsch_pkg::PH_SNI_NAME: begin
                                o_kind = tlsch_pkg::K_SNI; o_aux = enum_reg;
                                have = (ekind_reg == 8'd0);
                            end
                            default: begin
                                o_kind = tlsch_pkg::K_ALPN; o_aux = enum_reg;
                            end
                        endcase
                        if (!have) begin
                            o_kind = tlsch_pkg::K_NONE; o_val = '0; o_aux = '0; o_pos = '0;
                        end
                        pos_next = pos_reg + 16'd1;
                        entry_next = (entry_reg != 16'd0) ? entry_reg - 16'd1 : entry_reg;
                        if (entry_next == 16'd0) begin
                            fc_next = '0; half_next = 1'b0;
                            case (phase_reg)
                                tlsch_pkg::PH_SID: phase_next = tlsch_pkg::PH_CSLEN;
                                tlsch_pkg::PH_CM:  phase_next = tlsch_pkg::PH_EXTLEN;
                                tlsch_pkg::PH_PF_BODY:
                                    phase_next = (inner_next == 16'd0) ?
                                        tlsch_pkg::PH_EXTHDR : tlsch_pkg::PH_SKIP;
                                tlsch_pkg::PH_SNI_NAME: begin
                                    enum_next = enum_reg + 16'd1;
                                    phase_next = (inner_next == 16'd0) ?
                                        tlsch_pkg::PH_EXTHDR : tlsch_pkg::PH_SNI_EH;
                                end
                                default: begin
                                    enum_next = enum_reg + 16'd1;
                                    phase_next = (inner_next == 16'd0) ?
                                        tlsch_pkg::PH_EXTHDR : tlsch_pkg::PH_ALPN_PLEN;
                                end
                            endcase
                        end
                    end
                    tlsch_pkg::PH_CSLEN, tlsch_pkg::PH_EXTLEN: begin
                        if (fc_reg == 16'd0) asm_next = {data_byte, 8'd0};
                        else begin
                            fc_next = '0; half_next = 1'b0;
                            if (phase_reg == tlsch_pkg::PH_CSLEN) begin
                                entry_next = word; pos_next = '0;
                                phase_next = (word != 16'd0) ? tlsch_pkg::PH_CS
                                                             : tlsch_pkg::PH_CMLEN;
                            end else begin
                                extrem_next = word;
                                phase_next = tlsch_pkg::PH_EXTHDR;
                            end
                        end
                    end
                    tlsch_pkg::PH_CS, tlsch_pkg::PH_L16_BODY: begin
                        if (!half_reg) begin
                            asm_next = {data_byte, 8'd0}; half_next = 1'b1;
                        end else begin
                            half_next = 1'b0; have = 1'b1; o_val = word; o_pos = pos_reg;
                            pos_next = pos_reg + 16'd1;
                            if (phase_reg == tlsch_pkg::PH_CS) o_kind = tlsch_pkg::K_CIPHER;
                            else if (etype_reg == tlsch_pkg::EXT_SIGALG)
                                o_kind = tlsch_pkg::K_SIGALG;
                            else o_kind = tlsch_pkg::K_GROUP;
                        end
                        entry_next = (entry_reg != 16'd0) ? entry_reg - 16'd1 : entry_reg;
                        if (entry_next == 16'd0) begin
                            fc_next = '0; half_next = 1'b0;
                            if (phase_reg == tlsch_pkg::PH_CS)
                                phase_next = tlsch_pkg::PH_CMLEN;
                            else
                                phase_next = (inner_next == 16'd0) ?
                                    tlsch_pkg::PH_EXTHDR : tlsch_pkg::PH_SKIP;
                        end
                    end
                    tlsch_pkg::PH_CMLEN: begin
                        entry_next = {8'd0, data_byte}; pos_next = '0;
                        phase_next = (data_byte != 8'd0) ? tlsch_pkg::PH_CM
                                                         : tlsch_pkg::PH_EXTLEN;
                        fc_next = '0; half_next = 1'b0;
                    end
                    tlsch_pkg::PH_EXTHDR: begin
                        if (fc_reg == 16'd0) etype_next = {data_byte, 8'd0};
                        else if (fc_reg == 16'd1) etype_next = etype_reg | {8'd0, data_byte};
                        else if (fc_reg == 16'd2) asm_next = {data_byte, 8'd0};
                        else begin
                            inner_next = word;
                            enum_next = '0; pos_next = '0;
                            if (etype_reg == tlsch_pkg::EXT_STATUS ||
                                !(etype_reg == tlsch_pkg::EXT_SNI ||
                                  etype_reg == tlsch_pkg::EXT_GROUPS ||
                                  etype_reg == tlsch_pkg::EXT_SIGALG ||
                                  etype_reg == tlsch_pkg::EXT_PTFMT ||
                                  etype_reg == tlsch_pkg::EXT_ALPN)) begin
                                have = 1'b1; o_val = etype_reg; o_aux = word;
                                o_kind = (etype_reg == tlsch_pkg::EXT_STATUS) ?
                                         tlsch_pkg::K_OCSP : tlsch_pkg::K_OTHER;
                                fc_next = '0; half_next = 1'b0;
                                phase_next = (word == 16'd0) ? tlsch_pkg::PH_EXTHDR
                                                             : tlsch_pkg::PH_SKIP;
                            end else if (etype_reg == tlsch_pkg::EXT_PTFMT) begin
                                if (word < 16'd1) err_next = tlsch_pkg::ST_EXTLEN;
                                else begin
                                    phase_next = tlsch_pkg::PH_PF_LEN;
                                    fc_next = '0; half_next = 1'b0;
                                end
                            end else if (word < 16'd2) begin
                                err_next = tlsch_pkg::ST_EXTLEN;
                            end else begin
                                fc_next = '0; half_next = 1'b0;
                                if (etype_reg == tlsch_pkg::EXT_SNI)
                                    phase_next = tlsch_pkg::PH_SNI_LL;
                                else if (etype_reg == tlsch_pkg::EXT_ALPN)
                                    phase_next = tlsch_pkg::PH_ALPN_LL;
                                else phase_next = tlsch_pkg::PH_L16_LEN;
                            end
                        end
                    end
                    tlsch_pkg::PH_SKIP: begin
                        if (rest == 16'd0) begin
                            phase_next = tlsch_pkg::PH_EXTHDR; fc_next = '0; half_next = 1'b0;
                        end
                    end
                    tlsch_pkg::PH_SNI_LL, tlsch_pkg::PH_ALPN_LL: begin
                        if (fc_reg == 16'd0) asm_next = {data_byte, 8'd0};
                        else if (word > rest) err_next = tlsch_pkg::ST_EXTLEN;
                        else begin
                            fc_next = '0; half_next = 1'b0;
                            if (rest == 16'd0) phase_next = tlsch_pkg::PH_EXTHDR;
                            else if (phase_reg == tlsch_pkg::PH_SNI_LL)
                                phase_next = tlsch_pkg::PH_SNI_EH;
                            else phase_next = tlsch_pkg::PH_ALPN_PLEN;
                        end
                    end
                    tlsch_pkg::PH_SNI_EH: begin
                        if (fc_reg == 16'd0) ekind_next = data_byte;
                        else if (fc_reg == 16'd1) asm_next = {data_byte, 8'd0};
                        else if (len16 > rest) err_next = tlsch_pkg::ST_EXTLEN;
                        else begin
                            entry_next = len16; pos_next = '0;
                            fc_next = '0; half_next = 1'b0;
                            if (len16 == 16'd0) begin
                                enum_next = enum_reg + 16'd1;
                                phase_next = (rest == 16'd0) ? tlsch_pkg::PH_EXTHDR
                                                             : tlsch_pkg::PH_SNI_EH;
                            end else phase_next = tlsch_pkg::PH_SNI_NAME;
                        end
                    end
                    tlsch_pkg::PH_L16_LEN, tlsch_pkg::PH_PF_LEN: begin
                        if (phase_reg == tlsch_pkg::PH_L16_LEN && fc_reg == 16'd0)
                            asm_next = {data_byte, 8'd0};
                        else begin
                            if (phase_reg == tlsch_pkg::PH_PF_LEN) len16 = {8'd0, data_byte};
                            if (len16 > rest) err_next = tlsch_pkg::ST_EXTLEN;
                            else begin
                                entry_next = len16; pos_next = '0;
                                fc_next = '0; half_next = 1'b0;
                                if (len16 == 16'd0)
                                    phase_next = (rest == 16'd0) ? tlsch_pkg::PH_EXTHDR
                                                                 : tlsch_pkg::PH_SKIP;
                                else if (phase_reg == tlsch_pkg::PH_L16_LEN)
                                    phase_next = tlsch_pkg::PH_L16_BODY;
                                else phase_next = tlsch_pkg::PH_PF_BODY;
                            end
                        end
                    end
                    tlsch_pkg::PH_ALPN_PLEN: begin
                        if ({8'd0, data_byte} > rest) err_next = tlsch_pkg::ST_EXTLEN;
                        else begin
                            entry_next = {8'd0, data_byte}; pos_next = '0;
                            fc_next = '0; half_next = 1'b0;
                            if (data_byte == 8'd0) begin
                                enum_next = enum_reg + 16'd1;
                                phase_next = (rest == 16'd0) ? tlsch_pkg::PH_EXTHDR
                                                             : tlsch_pkg::PH_ALPN_PLEN;
                            end else phase_next = tlsch_pkg::PH_ALPN_NAME;
                        end
                    end
                    default: ;
                endcase
            end
        end

        if (err_next != tlsch_pkg::ST_OK) stat = err_next;
        else if (phase_next < tlsch_pkg::PH_EXTHDR) stat = tlsch_pkg::ST_BADLEN;
        else if (phase_next == tlsch_pkg::PH_EXTHDR && fc_next == 16'd0 &&
                 extrem_next == 16'd0) stat = tlsch_pkg::ST_OK;
        else stat = tlsch_pkg::ST_EXTLEN;

        res_have     = have || last_byte;
        res.kind     = o_kind;
        res.value    = o_val;
        res.aux      = o_aux;
        res.position = o_pos;
        res.done_res = last_byte;
        res.status   = last_byte ? stat : tlsch_pkg::ST_OK;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last_byte)) begin
            phase_reg  <= tlsch_pkg::PH_REC;
            fc_reg     <= '0;
            extrem_reg <= '0;
            inner_reg  <= '0;
            entry_reg  <= '0;
            asm_reg    <= '0;
            etype_reg  <= '0;
            enum_reg   <= '0;
            ekind_reg  <= '0;
            err_reg    <= '0;
            half_reg   <= 1'b0;
            pos_reg    <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            fc_reg     <= fc_next;
            extrem_reg <= extrem_next;
            inner_reg  <= inner_next;
            entry_reg  <= entry_next;
            asm_reg    <= asm_next;
            etype_reg  <= etype_next;
            enum_reg   <= enum_next;
            ekind_reg  <= ekind_next;
            err_reg    <= err_next;
            half_reg   <= half_next;
            pos_reg    <= pos_next;
        end
    end

    ap_err_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg != tlsch_pkg::ST_OK && !(step && last_byte) |=> $stable(err_reg))
        else $error("latched error changed");
    ap_last_have: assert property (@(posedge aclk) disable iff (!aresetn)
        last_byte |-> res_have) else $error("final beat without result");
    ap_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= tlsch_pkg::PH_ALPN_NAME) else $error("illegal phase");

endmodule

// ===== src/tlsch_fifo.sv =====
// Two-entry result queue between the parser front end and the output port.
// Depends on tlsch_pkg.
module tlsch_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_en,
    input  tlsch_pkg::result_t wr_data,
    output logic               full,
    output logic               rd_valid,
    input  logic               rd_en,
    output tlsch_pkg::result_t rd_data
);

    tlsch_pkg::result_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (wr_en) mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (wr_en) wp_reg <= ~wp_reg;
            if (rd_en) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    ap_no_over: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !wr_en) else $error("queue overflow");
    ap_no_under: assert property (@(posedge aclk) disable iff (!aresetn)
        !rd_valid |-> !rd_en) else $error("queue underflow");
    ap_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'd2) else $error("count out of range");

endmodule
